>>> design/ssm_pkg.sv
package ssm_pkg;

  localparam int MaxElements = 64;
  localparam int ExpTableBits = 10;
  localparam int IdxW = $clog2(MaxElements);
  localparam int CntW = $clog2(MaxElements + 1);
  localparam logic [16:0] Log2eQ16 = 17'd94548;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_EXP_RD,
    ST_EXP_MUL,
    ST_EXP_FAC,
    ST_EXP_RND,
    ST_EXP_OUT,
    ST_DIV_RD,
    ST_DIV_LD,
    ST_DIV_RUN,
    ST_EMIT
  } ssm_state_t;

  // 2^-(2^-k) for k = 1..14, Q2.30
  function automatic logic [31:0] exp2_factor(input logic [3:0] k);
    logic [31:0] f;
    case (k)
      4'd1: f = 32'd759250125;
      4'd2: f = 32'd902905651;
      4'd3: f = 32'd984625594;
      4'd4: f = 32'd1028218693;
      4'd5: f = 32'd1050733751;
      4'd6: f = 32'd1062175491;
      4'd7: f = 32'd1067942999;
      4'd8: f = 32'd1070838486;
      4'd9: f = 32'd1072289172;
      4'd10: f = 32'd1073015252;
      4'd11: f = 32'd1073378477;
      4'd12: f = 32'd1073560135;
      4'd13: f = 32'd1073650976;
      4'd14: f = 32'd1073696399;
      default: f = 32'd1073741824;
    endcase
    return f;
  endfunction

endpackage

>>> design/ssm_divider.sv
module ssm_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [32:0] dividend,
  input  logic [22:0] divisor,
  output logic        done,
  output logic [15:0] quotient
);
  import ssm_pkg::*;

  logic [32:0] rem_r, rem_nxt;
  logic [32:0] quo_r, quo_nxt;
  logic [5:0]  step_r, step_nxt;
  logic        busy_r, busy_nxt;
  logic [33:0] trial;

  // one quotient bit per cycle, restoring
  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    trial    = '0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      step_nxt = 6'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      trial = {rem_r, quo_r[32]} - {11'd0, divisor};
      if (!trial[33]) begin
        rem_nxt = trial[32:0];
        quo_nxt = {quo_r[31:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[31:0], quo_r[32]};
        quo_nxt = {quo_r[31:0], 1'b0};
      end
      step_nxt = step_r + 6'd1;
      if (step_r == 6'd32) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done = !busy_r && (step_r == 6'd33);
  assign quotient = (divisor == '0) ? 16'd0 :
                    (quo_r[32:16] != '0) ? 16'hFFFF : quo_r[15:0];
endmodule

>>> design/stable_softmax_unit.sv
// after the closing item, an exponential pass runs for each element (read, log2e
// scale, table factor steps, round, store), then a division pass runs for each
// element (read, divider start, bit-serial divide, emit held until out_ready)
// throughput: one item per cycle while loading; no item is taken during the passes
// reset: synchronous active-low rst_n clears count, maximum, sum and sequencer
module stable_softmax_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [15:0] in_logit,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_probability,
  output logic        out_is_last_res
);
  import ssm_pkg::*;

  ssm_state_t state_r, state_nxt;
  logic [15:0] logit_mem [MaxElements];
  logic [16:0] exp_mem [MaxElements];
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [CntW-1:0] idx_r, idx_nxt;
  logic signed [15:0] max_r, max_nxt;
  logic [22:0] sum_r, sum_nxt;
  logic [15:0] logit_rd_r;
  logic [16:0] exp_rd_r;
  logic [40:0] t_r;
  logic [31:0] acc_r;
  logic [3:0]  k_r;
  logic [16:0] exp_val;
  logic [15:0] prob_r;
  logic        div_start, div_done;
  logic [15:0] div_q;
  logic        accept, last_elem;
  logic [16:0] neg_d;
  logic [16:0] n_int;
  logic [5:0]  shamt;
  logic [32:0] rnd_sum;
  logic [5:0]  fac_bit_idx;

  assign accept = in_valid && in_ready;
  assign last_elem = in_is_last || (cnt_r == CntW'(MaxElements - 1));
  assign neg_d = {max_r[15], max_r} - {logit_rd_r[15], logit_rd_r};
  assign fac_bit_idx = 6'd24 - {2'b00, k_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD:    if (accept && last_elem) state_nxt = ST_EXP_RD;
      ST_EXP_RD:  state_nxt = ST_EXP_MUL;
      ST_EXP_MUL: state_nxt = ST_EXP_FAC;
      ST_EXP_FAC: if (k_r == 4'(ExpTableBits)) state_nxt = ST_EXP_RND;
      ST_EXP_RND: state_nxt = ST_EXP_OUT;
      ST_EXP_OUT: state_nxt = (idx_r + 1'b1 == cnt_r) ? ST_DIV_RD : ST_EXP_RD;
      ST_DIV_RD:  state_nxt = ST_DIV_LD;
      ST_DIV_LD:  state_nxt = ST_DIV_RUN;
      ST_DIV_RUN: if (div_done) state_nxt = ST_EMIT;
      ST_EMIT:    if (out_ready)
                    state_nxt = (idx_r + 1'b1 == cnt_r) ? ST_LOAD : ST_DIV_RD;
      default:    state_nxt = ST_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = (state_r == ST_LOAD);
    out_valid = (state_r == ST_EMIT);
    div_start = (state_r == ST_DIV_LD);
  end

  assign out_probability = prob_r;
  assign out_is_last_res = (idx_r + 1'b1 == cnt_r);

  // exponent rounding shift
  always_comb begin
    n_int = t_r[40:24];
    shamt = 6'(14 + 32'(n_int[4:0]));
    rnd_sum = {1'b0, acc_r} + (33'd1 << (shamt - 6'd1));
    exp_val = (n_int >= 17'd31) ? 17'd0 : 17'(rnd_sum >> shamt);
  end

  // counters and accumulators
  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    max_nxt = max_r;
    sum_nxt = sum_r;
    if (accept) begin
      if (in_logit > max_r) max_nxt = in_logit;
      cnt_nxt = cnt_r + 1'b1;
      idx_nxt = '0;
      sum_nxt = '0;
    end
    if (state_r == ST_EXP_OUT) begin
      sum_nxt = sum_r + 23'(exp_val);
      idx_nxt = (idx_r + 1'b1 == cnt_r) ? '0 : idx_r + 1'b1;
    end
    if (state_r == ST_EMIT && out_ready) begin
      if (idx_r + 1'b1 == cnt_r) begin
        cnt_nxt = '0;
        idx_nxt = '0;
        max_nxt = 16'sh8000;
        sum_nxt = '0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r <= '0;
      idx_r <= '0;
      max_r <= 16'sh8000;
      sum_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
      max_r <= max_nxt;
      sum_r <= sum_nxt;
    end
  end

  // vector stores
  always_ff @(posedge clk) begin
    if (accept) logit_mem[cnt_r[IdxW-1:0]] <= in_logit;
    if (state_r == ST_EXP_OUT) exp_mem[idx_r[IdxW-1:0]] <= exp_val;
    logit_rd_r <= logit_mem[idx_r[IdxW-1:0]];
    exp_rd_r <= exp_mem[idx_r[IdxW-1:0]];
  end

  // multiplications: log2e scale, then one table factor per step whose bit of t is set
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_EXP_MUL: begin
        t_r <= 41'(neg_d) * 41'(Log2eQ16);
        acc_r <= 32'd1073741824;
        k_r <= 4'd1;
      end
      ST_EXP_FAC: begin
        if (t_r[fac_bit_idx]) acc_r <= 32'((64'(acc_r) * 64'(exp2_factor(k_r))
                                           + 64'd536870912) >> 30);
        k_r <= k_r + 4'd1;
      end
      default: ;
    endcase
    if (state_r == ST_DIV_RUN && div_done) prob_r <= div_q;
  end

  ssm_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend({exp_rd_r, 16'd0} + 33'(sum_r >> 1)),
    .divisor(sum_r), .done(div_done), .quotient(div_q)
  );

`ifndef SYNTHESIS
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_LOAD) |-> !in_ready) else $error("input taken while busy");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(MaxElements)) else $error("count overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_probability)) else $error("result changed");
`endif
endmodule

>>> sim/stable_softmax_unit_test.sv
`timescale 1ns / 100ps

module stable_softmax_unit_test;
  import ssm_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] in_logit;
  logic               in_is_last;
  logic               out_valid;
  logic               out_ready;
  logic [15:0]        out_probability;
  logic               out_is_last_res;

  // expected probability items, oldest first
  logic [15:0] want_prob_q[$];
  logic        want_last_q[$];

  // predictor copy of the vector state
  logic signed [15:0] vec_logits[MaxElements];
  int                 vec_count;
  logic signed [15:0] vec_max;

  int mismatches;
  int idle_pct;
  int stall_pct;

  stable_softmax_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_logit        (in_logit),
    .in_is_last      (in_is_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_probability (out_probability),
    .out_is_last_res (out_is_last_res)
  );

  // clock
  always #5 clk = ~clk;

  // exp(-neg_d/256) in unsigned Q1.16 via base-2 factor table
  function automatic logic [16:0] q16_exp(input logic [16:0] neg_d);
    logic [63:0] t;
    logic [63:0] n;
    logic [63:0] acc;
    logic [63:0] f;
    int          shift;
    t = 64'(neg_d) * 64'd94548;
    n = t >> 24;
    acc = 64'd1073741824;
    for (int k = 1; k <= ExpTableBits && k <= 14; k++) begin
      if (t[24 - k]) begin
        case (k)
          1: f = 64'd759250125;
          2: f = 64'd902905651;
          3: f = 64'd984625594;
          4: f = 64'd1028218693;
          5: f = 64'd1050733751;
          6: f = 64'd1062175491;
          7: f = 64'd1067942999;
          8: f = 64'd1070838486;
          9: f = 64'd1072289172;
          10: f = 64'd1073015252;
          11: f = 64'd1073378477;
          12: f = 64'd1073560135;
          13: f = 64'd1073650976;
          default: f = 64'd1073696399;
        endcase
        acc = (acc * f + (64'd1 << 29)) >> 30;
      end
    end
    if (n >= 31) return 17'd0;
    shift = 14 + int'(n);
    return 17'((acc + (64'd1 << (shift - 1))) >> shift);
  endfunction

  // update the vector and queue probabilities when it closes
  task automatic predict_softmax(input logic signed [15:0] logit, input logic last);
    logic [16:0] exps[MaxElements];
    logic [22:0] sum;
    logic [63:0] q;
    int          d;
    if (vec_count >= MaxElements) vec_count = 0;
    vec_logits[vec_count] = logit;
    if (logit > vec_max) vec_max = logit;
    vec_count++;
    if (!last && vec_count < MaxElements) return;
    sum = '0;
    for (int i = 0; i < vec_count; i++) begin
      d = int'(vec_max) - int'(vec_logits[i]);
      exps[i] = q16_exp(17'(d));
      sum = sum + 23'(exps[i]);
    end
    for (int i = 0; i < vec_count; i++) begin
      q = 0;
      if (sum != 0) begin
        q = ((64'(exps[i]) << 16) + 64'(sum >> 1)) / 64'(sum);
        if (q > 65535) q = 65535;
      end
      want_prob_q.push_back(q[15:0]);
      want_last_q.push_back(i + 1 == vec_count);
    end
    vec_count = 0;
    vec_max = 16'sh8000;
  endtask

  // send one item, with random idle cycles first
  task automatic send_logit(input logic signed [15:0] logit, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_logit   <= logit;
    in_is_last <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_softmax(logit, last);
  endtask

  // random receiver stall
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (want_prob_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: prob %0d last %0b", out_probability, out_is_last_res);
      end else begin
        logic [15:0] wp;
        logic        wl;
        wp = want_prob_q.pop_front();
        wl = want_last_q.pop_front();
        if (wp !== out_probability || wl !== out_is_last_res) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: prob exp %0d got %0d, last exp %0b got %0b",
                     wp, out_probability, wl, out_is_last_res);
        end
      end
    end
  end

  task automatic test_directed;
    // single element, saturated
    send_logit(16'sd0, 1'b1);
    send_logit(16'sh7fff, 1'b1);
    // extremes of range, deep underflow
    send_logit(16'sh8000, 1'b0);
    send_logit(16'sd32767, 1'b1);
    // ties for maximum
    send_logit(16'sd256, 1'b0);
    send_logit(16'sd256, 1'b0);
    send_logit(-16'sd256, 1'b1);
    // all equal minimum
    send_logit(16'sh8000, 1'b0);
    send_logit(16'sh8000, 1'b1);
    // a late large maximum leaves the other items far below it
    send_logit(16'sd0, 1'b0);
    send_logit(-16'sd1, 1'b0);
    send_logit(-16'sd3, 1'b0);
    send_logit(-16'sd177, 1'b0);
    send_logit(-16'sd2048, 1'b0);
    send_logit(16'sh5555, 1'b0);
    send_logit(-16'sh2aab, 1'b1);
  endtask

  // overflow: a full store without a last flag closes the vector
  task automatic test_overflow;
    for (int i = 0; i < MaxElements; i++)
      send_logit(16'($urandom_range(65535)), 1'b0);
    send_logit(16'sd100, 1'b1);
  endtask

  task automatic test_random(input int items);
    int sent;
    int len;
    int spread;
    logic signed [15:0] base;
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(64, 20) : $urandom_range(8, 1);
      base = 16'($urandom_range(65535));
      spread = 1 << $urandom_range(15, 2);
      for (int i = 0; i < len; i++) begin
        logic signed [15:0] v;
        if ($urandom_range(4) == 0) v = 16'($urandom_range(65535));
        else v = 16'(int'(base) + int'($urandom_range(spread)) - spread / 2);
        send_logit(v, (i == len - 1) || $urandom_range(30) == 0);
        sent++;
      end
    end
  endtask

  task automatic wait_drain;
    in_valid <= 1'b0;
    while (want_prob_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  initial begin
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_logit   = '0;
    in_is_last = 1'b0;
    out_ready  = 1'b0;
    vec_count  = 0;
    vec_max    = 16'sh8000;
    mismatches = 0;
    idle_pct   = 29;
    stall_pct  = 29;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_overflow();
    test_random(30);
    // stretch with no idling on either side
    idle_pct  = 0;
    stall_pct = 0;
    test_random(25);
    idle_pct  = 29;
    stall_pct = 29;
    test_random(25);
    wait_drain();
    if (mismatches == 0) $display("stable_softmax_unit_test: PASS");
    else $display("stable_softmax_unit_test: FAIL");
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("stable_softmax_unit_test: FAIL");
    $finish;
  end

endmodule

>>> files.f
design/ssm_pkg.sv
design/ssm_divider.sv
design/stable_softmax_unit.sv
sim/stable_softmax_unit_test.sv
